/* src/lpfp_pkg.sv */
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types for the length-prefixed frame parser: section codes and the
// per-beat result record.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned TAG_W  = 3;
  localparam int unsigned OFF_W  = 16;
  localparam int unsigned SRC_W  = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned CSUM_W = 32;

  typedef enum logic [TAG_W-1:0] {
    SEC_SOURCE   = 3'd0,
    SEC_CMDLEN   = 3'd1,
    SEC_PAYLEN   = 3'd2,
    SEC_CHECKSUM = 3'd3,
    SEC_COMMAND  = 3'd4,
    SEC_PAYLOAD  = 3'd5
  } section_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic [TAG_W-1:0]  tag;
    logic [OFF_W-1:0]  offset;
    logic              done;
    logic [SRC_W-1:0]  source_id;
    logic [LEN_W-1:0]  command_len;
    logic [LEN_W-1:0]  payload_len;
    logic [CSUM_W-1:0] checksum;
  } lpfp_result_t;

endpackage

/* src/length_prefixed_frame_parser.sv */
// An accepted input beat passes through the input register, then the result
//   register, before out_valid rises.
// Throughput: 1 byte per cycle unless the result side stalls; the frame state
//   updates in the same cycle a byte moves from the input to the result register.
// Reset: synchronous, active low; clears both valid flags and the frame state,
//   the parser starts in the source index section.
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser
// Streams received bytes through, tagging each with its frame section and
// offset and presenting the assembled header on the last byte of a frame.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser
  import lpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_byte,
  output logic [TAG_W-1:0]  out_section_tag,
  output logic [OFF_W-1:0]  out_section_offset,
  output logic              out_frame_done,
  output logic [SRC_W-1:0]  out_source_id,
  output logic [LEN_W-1:0]  out_command_len,
  output logic [LEN_W-1:0]  out_payload_len,
  output logic [CSUM_W-1:0] out_frame_checksum
);

  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              out_vld_r;
  lpfp_result_t      res_r;
  lpfp_result_t      res_nxt;
  logic              advance;

  // move a beat into the result register when it is empty or being drained
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  lpfp_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .rx_byte (in_byte_r),
    .result  (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_rx_byte;
    end
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_byte           = res_r.data;
  assign out_section_tag    = res_r.tag;
  assign out_section_offset = res_r.offset;
  assign out_frame_done     = res_r.done;
  assign out_source_id      = res_r.source_id;
  assign out_command_len    = res_r.command_len;
  assign out_payload_len    = res_r.payload_len;
  assign out_frame_checksum = res_r.checksum;

endmodule

/* src/lpfp_parse.sv */
// ----------------------------------------------------------------------------
// lpfp_parse
// Frame state and header capture. Given one byte and a step strobe, tags the
// byte, assembles the header fields and advances the section walk.
// ----------------------------------------------------------------------------
module lpfp_parse
  import lpfp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output lpfp_result_t      result
);

  localparam logic [LEN_W-1:0] LEN_SOURCE   = LEN_W'(1);
  localparam logic [LEN_W-1:0] LEN_CMDLEN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_PAYLEN   = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_CHECKSUM = LEN_W'(4);

  section_t          section_r, section_nxt;
  logic [OFF_W-1:0]  offset_r, offset_nxt;
  logic [SRC_W-1:0]  source_r, source_nxt;
  logic [LEN_W-1:0]  cmd_len_r, cmd_len_nxt;
  logic [LEN_W-1:0]  pay_len_r, pay_len_nxt;
  logic [CSUM_W-1:0] csum_r, csum_nxt;

  // values after capture of this beat, before any end-of-frame clear
  section_t          sec;
  logic [OFF_W-1:0]  off;
  logic [SRC_W-1:0]  src_cap;
  logic [LEN_W-1:0]  cmd_cap;
  logic [LEN_W-1:0]  pay_cap;
  logic [CSUM_W-1:0] csum_cap;
  logic [LEN_W-1:0]  sec_len;
  logic              sec_last;
  logic              frame_end;
  section_t          sec_after;

  // unused codes fall back to the source section
  always_comb begin
    if (section_r > SEC_PAYLOAD) begin
      sec = SEC_SOURCE;
      off = '0;
    end else begin
      sec = section_r;
      off = offset_r;
    end
  end

  // header capture and result
  always_comb begin
    src_cap  = source_r;
    cmd_cap  = cmd_len_r;
    pay_cap  = pay_len_r;
    csum_cap = csum_r;
    unique case (sec)
      SEC_SOURCE: begin
        src_cap = rx_byte;
      end
      SEC_CMDLEN: begin
        cmd_cap = off[0] ? (cmd_len_r | {rx_byte, 8'h00}) : (cmd_len_r | {8'h00, rx_byte});
      end
      SEC_PAYLEN: begin
        pay_cap = off[0] ? (pay_len_r | {rx_byte, 8'h00}) : (pay_len_r | {8'h00, rx_byte});
      end
      SEC_CHECKSUM: begin
        csum_cap = csum_r | (CSUM_W'(rx_byte) << {off[1:0], 3'b000});
      end
      default: begin
      end
    endcase

    result.data        = rx_byte;
    result.tag         = sec;
    result.offset      = off;
    result.done        = frame_end;
    result.source_id   = src_cap;
    result.command_len = cmd_cap;
    result.payload_len = pay_cap;
    result.checksum    = csum_cap;
  end

  // section walk, skipping empty command and payload sections
  always_comb begin
    unique case (sec)
      SEC_SOURCE:   sec_len = LEN_SOURCE;
      SEC_CMDLEN:   sec_len = LEN_CMDLEN;
      SEC_PAYLEN:   sec_len = LEN_PAYLEN;
      SEC_CHECKSUM: sec_len = LEN_CHECKSUM;
      SEC_COMMAND:  sec_len = cmd_cap;
      default:      sec_len = pay_cap;
    endcase
    sec_last = ({1'b0, off} + (OFF_W+1)'(1)) >= {1'b0, sec_len};

    frame_end = 1'b0;
    sec_after = SEC_SOURCE;
    unique case (sec)
      SEC_SOURCE:   sec_after = SEC_CMDLEN;
      SEC_CMDLEN:   sec_after = SEC_PAYLEN;
      SEC_PAYLEN:   sec_after = SEC_CHECKSUM;
      SEC_CHECKSUM: begin
        if (cmd_cap != '0) begin
          sec_after = SEC_COMMAND;
        end else if (pay_cap != '0) begin
          sec_after = SEC_PAYLOAD;
        end else begin
          frame_end = sec_last;
        end
      end
      SEC_COMMAND: begin
        if (pay_cap != '0) begin
          sec_after = SEC_PAYLOAD;
        end else begin
          frame_end = sec_last;
        end
      end
      default: begin
        frame_end = sec_last;
      end
    endcase

    if (frame_end) begin
      section_nxt = SEC_SOURCE;
      offset_nxt  = '0;
      source_nxt  = '0;
      cmd_len_nxt = '0;
      pay_len_nxt = '0;
      csum_nxt    = '0;
    end else begin
      source_nxt  = src_cap;
      cmd_len_nxt = cmd_cap;
      pay_len_nxt = pay_cap;
      csum_nxt    = csum_cap;
      if (sec_last) begin
        section_nxt = sec_after;
        offset_nxt  = '0;
      end else begin
        section_nxt = sec;
        offset_nxt  = off + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      section_r <= SEC_SOURCE;
      offset_r  <= '0;
      source_r  <= '0;
      cmd_len_r <= '0;
      pay_len_r <= '0;
      csum_r    <= '0;
    end else if (step) begin
      section_r <= section_nxt;
      offset_r  <= offset_nxt;
      source_r  <= source_nxt;
      cmd_len_r <= cmd_len_nxt;
      pay_len_r <= pay_len_nxt;
      csum_r    <= csum_nxt;
    end
  end

endmodule

/* sim/length_prefixed_frame_parser_tb.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_tb
// Drives whole frames byte by byte into the parser with random gaps on the
// input side and random stalls on the result side. A behavioral parser runs
// alongside and queues the expected tag, offset and header view for every
// accepted beat. Each result beat is checked field by field against it.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_tb;
  import lpfp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_GAP        = 19;
  localparam int unsigned QUIET_LIMIT    = 1000;
  localparam int unsigned RANDOM_BYTES   = 800;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned MAX_MSG_LINES  = 40;

  logic              clk;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_rx_byte = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic [TAG_W-1:0]  out_section_tag;
  logic [OFF_W-1:0]  out_section_offset;
  logic              out_frame_done;
  logic [SRC_W-1:0]  out_source_id;
  logic [LEN_W-1:0]  out_command_len;
  logic [LEN_W-1:0]  out_payload_len;
  logic [CSUM_W-1:0] out_frame_checksum;

  length_prefixed_frame_parser u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_section_tag    (out_section_tag),
    .out_section_offset (out_section_offset),
    .out_frame_done     (out_frame_done),
    .out_source_id      (out_source_id),
    .out_command_len    (out_command_len),
    .out_payload_len    (out_payload_len),
    .out_frame_checksum (out_frame_checksum)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Behavioral parser state
  // ---------------------------------------------------------------------------
  section_t          cur_sec = SEC_SOURCE;
  logic [OFF_W-1:0]  cur_off = '0;
  logic [SRC_W-1:0]  src_q   = '0;
  logic [LEN_W-1:0]  cmd_q   = '0;
  logic [LEN_W-1:0]  pay_q   = '0;
  logic [CSUM_W-1:0] csum_q  = '0;

  lpfp_result_t pending_beats[$];

  bit          idle_en = 1'b1;
  int unsigned bytes_sent;
  int unsigned frames_sent;
  int unsigned beats_checked;
  int unsigned mismatch_count;
  int unsigned quiet_cycles;

  function automatic int unsigned section_bytes(section_t s);
    case (s)
      SEC_SOURCE:   return 1;
      SEC_CMDLEN:   return 2;
      SEC_PAYLEN:   return 2;
      SEC_CHECKSUM: return 4;
      SEC_COMMAND:  return 32'(cmd_q);
      SEC_PAYLOAD:  return 32'(pay_q);
      default:      return 0;
    endcase
  endfunction

  function automatic lpfp_result_t parse_byte(logic [BYTE_W-1:0] b);
    lpfp_result_t r;
    int           nxt;
    logic         done;
    done = 1'b0;
    case (cur_sec)
      SEC_SOURCE:   src_q  = b;
      SEC_CMDLEN:   cmd_q  = cmd_q | (LEN_W'(b) << (cur_off[0] ? 8 : 0));
      SEC_PAYLEN:   pay_q  = pay_q | (LEN_W'(b) << (cur_off[0] ? 8 : 0));
      SEC_CHECKSUM: csum_q = csum_q | (CSUM_W'(b) << (8 * cur_off[1:0]));
      default: ;
    endcase
    r.data   = b;
    r.tag    = cur_sec;
    r.offset = cur_off;
    if (int'(cur_off) + 1 >= int'(section_bytes(cur_sec))) begin
      // hop over empty command / payload sections
      nxt = int'(cur_sec) + 1;
      while (nxt <= int'(SEC_PAYLOAD) && section_bytes(section_t'(nxt)) == 0) nxt++;
      if (nxt > int'(SEC_PAYLOAD)) begin
        done = 1'b1;
      end else begin
        cur_sec = section_t'(nxt);
        cur_off = '0;
      end
    end else begin
      cur_off = cur_off + 1'b1;
    end
    r.done        = done;
    r.source_id   = src_q;
    r.command_len = cmd_q;
    r.payload_len = pay_q;
    r.checksum    = csum_q;
    if (done) begin
      cur_sec = SEC_SOURCE;
      cur_off = '0;
      src_q   = '0;
      cmd_q   = '0;
      pay_q   = '0;
      csum_q  = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_MSG_LINES) $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("beat %0d %s: got 0x%0h, expected 0x%0h",
                                beats_checked, name, got, want));
  endtask

  task automatic check_beat();
    lpfp_result_t want;
    if (pending_beats.size() == 0) begin
      report_mismatch($sformatf("result beat %0d with nothing pending", beats_checked));
    end else begin
      want = pending_beats.pop_front();
      check_field("byte",     32'(out_byte),           32'(want.data));
      check_field("tag",      32'(out_section_tag),    32'(want.tag));
      check_field("offset",   32'(out_section_offset), 32'(want.offset));
      check_field("done",     32'(out_frame_done),     32'(want.done));
      check_field("source",   32'(out_source_id),      32'(want.source_id));
      check_field("cmd_len",  32'(out_command_len),    32'(want.command_len));
      check_field("pay_len",  32'(out_payload_len),    32'(want.payload_len));
      check_field("checksum", out_frame_checksum,      want.checksum);
    end
    beats_checked++;
  endtask

  // predict first so a pass-through that returns a beat in the same cycle would still line up
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) pending_beats.push_back(parse_byte(in_rx_byte));
      if (out_valid && out_ready) check_beat();
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no beat moved for %0d cycles", $time, quiet_cycles);
      $display("** length_prefixed_frame_parser: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [SRC_W-1:0] src, input logic [LEN_W-1:0] cmd_len,
                            input logic [LEN_W-1:0] pay_len,
                            input logic [CSUM_W-1:0] csum);
    send_byte(src);
    send_byte(cmd_len[7:0]);
    send_byte(cmd_len[15:8]);
    send_byte(pay_len[7:0]);
    send_byte(pay_len[15:8]);
    for (int i = 0; i < 4; i++) send_byte(csum[8*i +: 8]);
    for (int i = 0; i < int'(cmd_len); i++) send_byte(BYTE_W'($urandom));
    for (int i = 0; i < int'(pay_len); i++) send_byte(BYTE_W'($urandom));
    frames_sent++;
  endtask

  // drop valid first so the last beat is not taken twice; letting the clock tick
  // lets the monitor queue that beat before the queue is polled
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_beats.size() > 0) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] random_section_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return '0;
    if (pick < 80) return LEN_W'($urandom_range(1, 6));
    if (pick < 96) return LEN_W'($urandom_range(7, 40));
    return LEN_W'($urandom_range(250, 300));
  endfunction

  task automatic test_empty_sections();
    send_frame(8'h00, 16'd0, 16'd0, 32'h0000_0000);
    send_frame(8'hFF, 16'd1, 16'd0, 32'hFFFF_FFFF);
    send_frame(8'h5A, 16'd0, 16'd1, 32'h8001_7FFE);
  endtask

  task automatic test_random_frames();
    int unsigned stop_at;
    int unsigned frame_no;
    stop_at  = bytes_sent + RANDOM_BYTES;
    frame_no = 0;
    while (bytes_sent < stop_at) begin
      idle_en = ($urandom_range(0, 5) != 0);
      send_frame(SRC_W'($urandom), random_section_len(), random_section_len(),
                 CSUM_W'($urandom));
      frame_no++;
      if (frame_no % 8 == 0) wait_drained();
    end
    idle_en = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_en = 1'b0;
    for (int i = 0; i < 12; i++)
      send_frame(SRC_W'($urandom), LEN_W'($urandom_range(0, 3)),
                 LEN_W'($urandom_range(0, 3)), CSUM_W'($urandom));
    idle_en = 1'b1;
  endtask

  // a command length with its high byte set carries offsets past 8 bits
  task automatic test_longest_frame();
    idle_en = 1'b0;
    send_frame(8'hA5, 16'h0102, 16'h0003, CSUM_W'($urandom));
    idle_en = 1'b1;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_sections();
    wait_drained();
    test_random_frames();
    test_back_to_back();
    test_longest_frame();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d bytes in %0d frames; %0d result beats checked.",
             bytes_sent, frames_sent, beats_checked);
    $display("Empty command/payload sections, gaps, stalls, drains and long sections.");
    if (mismatch_count == 0 && pending_beats.size() == 0) begin
      $display("** length_prefixed_frame_parser: PASSED **");
    end else begin
      $display("%0d mismatches, %0d beats outstanding", mismatch_count,
               pending_beats.size());
      $display("** length_prefixed_frame_parser: FAILED **");
    end
    $finish;
  end

endmodule
